// File: rtl/bhd_pkg.sv
// ----------------------------------------------------------------------------
// bhd_pkg: shared types, codes and the per-byte parse step
// Holds the parse state, the result record and the function that applies one
// (already swapped) byte of a block to the parse state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhd_pkg;

  // Parser phases
  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhHeader  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;
  localparam logic [1:0] PhTrunc   = 2'd3;

  // Result kinds
  localparam logic [1:0] KindHeader  = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindError   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgSecHdrEn   = 2'd0;
  localparam logic [1:0] CfgByteSwap   = 2'd1;
  localparam logic [1:0] CfgReplyMask  = 2'd2;

  // Data type code that announces the two-byte extension
  localparam logic [4:0] TypeExt = 5'h1F;

  // Result queue geometry
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = 2;
  localparam int unsigned OutCntW  = 3;

  typedef struct packed {
    logic [1:0]  phase;
    logic [16:0] size;
    logic [15:0] hdr_word;
    logic [20:0] type_latch;
    logic [15:0] tag_err;
    logic [31:0] time_latch;
    logic [3:0]  hdr_len;
  } parse_st_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  block_type;
    logic [8:0]  node_address;
    logic [20:0] data_type;
    logic [11:0] command_tag;
    logic [3:0]  error_code;
    logic [31:0] data_time;
    logic [16:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  typedef struct packed {
    parse_st_t st;
    logic      vld;
    result_t   res;
  } feed_t;

  // Apply one byte at block position pos; may produce one result.
  function automatic feed_t bhd_feed(parse_st_t s_in, logic [7:0] b, logic [16:0] pos,
                                     logic sec_en, logic [1:0] reply_mask);
    feed_t       o;
    parse_st_t   s;
    logic        is_last;
    logic        prim4;
    logic [2:0]  prim;
    logic [16:0] rem;
    logic [16:0] pos_rel;
    logic [3:0]  sec;
    s       = s_in;
    o.vld   = 1'b0;
    o.res   = '0;
    prim4   = 1'b0;
    prim    = 3'd2;
    rem     = '0;
    pos_rel = '0;
    sec     = '0;
    is_last = (({1'b0, pos} + 18'd1) == {1'b0, s.size});
    case (s.phase)
      PhPayload: begin
        o.vld              = 1'b1;
        o.res.kind         = KindPayload;
        o.res.payload_byte = b;
        o.res.last         = is_last;
      end
      PhHeader: begin
        if (pos == 17'd0) begin
          s.hdr_word = {b, 8'h00};
        end else if (pos == 17'd1) begin
          s.hdr_word   = {s.hdr_word[15:8], b};
          s.type_latch = {16'd0, b[4:0]};
          prim         = (b[4:0] == TypeExt) ? 3'd4 : 3'd2;
          if (s.size < {14'd0, prim}) begin
            s.phase = PhTrunc;
          end else begin
            rem = s.size - {14'd0, prim};
            if (sec_en && rem != 17'd0) begin
              sec = ((s.hdr_word[15:14] & reply_mask) != 2'd0) ? 4'd6 : 4'd2;
            end
            if (rem < {13'd0, sec}) begin
              s.phase = PhTrunc;
            end else begin
              s.hdr_len = {1'b0, prim} + sec;
            end
          end
        end else begin
          // Extension bytes, then tag/error word, then time word
          prim4   = (s.type_latch[4:0] == TypeExt) || (s.type_latch[20:5] != 16'd0);
          pos_rel = pos - (prim4 ? 17'd4 : 17'd2);
          if (prim4 && pos < 17'd4) begin
            s.type_latch = {s.type_latch[12:0], b};
          end else if (pos_rel < 17'd2) begin
            s.tag_err = {s.tag_err[7:0], b};
          end else begin
            s.time_latch = {s.time_latch[23:0], b};
          end
        end
        if (s.phase == PhHeader && pos != 17'd0 &&
            ({1'b0, pos} + 18'd1) == {14'd0, s.hdr_len}) begin
          o.vld                = 1'b1;
          o.res.kind           = KindHeader;
          o.res.block_type     = s.hdr_word[15:14];
          o.res.node_address   = s.hdr_word[13:5];
          o.res.data_type      = s.type_latch;
          o.res.command_tag    = s.tag_err[11:0];
          o.res.error_code     = s.tag_err[15:12];
          o.res.data_time      = s.time_latch;
          o.res.payload_length = s.size - {13'd0, s.hdr_len};
          o.res.last           = is_last;
          s.phase              = PhPayload;
        end else if (is_last) begin
          o.vld      = 1'b1;
          o.res.kind = KindError;
          o.res.last = 1'b1;
        end
      end
      PhTrunc: begin
        if (is_last) begin
          o.vld      = 1'b1;
          o.res.kind = KindError;
          o.res.last = 1'b1;
        end
      end
      default: begin
      end
    endcase
    o.st = s;
    return o;
  endfunction

endpackage

// File: rtl/block_header_deframer.sv
// ----------------------------------------------------------------------------
// block_header_deframer: byte-stream block header parser
// Splits each incoming block into one header result followed by its payload
// bytes, with optional pair swap, extended data type and secondary header.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------
//   in        | in_valid_i/in_ready_o | data_byte_i, block_size_i
//   out       | out_valid_o/out_ready_i | kind_o .. last_o (ten fields)
//   cfg       | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One byte is accepted per cycle. A byte yields up to two results (swapped
// pairs); they enter a 4-entry result queue that drains one per cycle, so
// in_ready_o drops while fewer than two slots are free. A result enters the
// queue as its byte is accepted. rst_ni clears the parser and queue at
// once; a stalled output only holds the queue, parsing continues while room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_header_deframer #(
  parameter int unsigned MAX_BLOCK_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [16:0] block_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  block_type_o,
  output logic [8:0]  node_address_o,
  output logic [20:0] data_type_o,
  output logic [11:0] command_tag_o,
  output logic [3:0]  error_code_o,
  output logic [31:0] data_time_o,
  output logic [16:0] payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o
);
  import bhd_pkg::*;

  localparam logic [31:0] MaxBytes = 32'(MAX_BLOCK_BYTES);

  logic        sec_en_q, swap_q;
  logic [1:0]  reply_mask_q;
  parse_st_t   st_q, st_d, st0;
  logic [16:0] pos_q, pos_d;
  logic [7:0]  held_q, held_d;
  logic [16:0] size_in;
  logic        pos_last;
  logic        f1_en, f2_en;
  logic [7:0]  f1_byte;
  logic [16:0] f1_pos;
  feed_t       f1, f2;
  logic        in_acc, out_acc;
  logic        w0_vld, w1_vld;
  result_t     w0_res, w1_res;
  result_t     fifo_q [OutDepth];
  logic [OutPtrW-1:0] wr_q, rd_q;
  logic [OutCntW-1:0] cnt_q, cnt_d;
  result_t     head;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_en_q     <= 1'b1;
      swap_q       <= 1'b0;
      reply_mask_q <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSecHdrEn:  sec_en_q     <= cfg_wdata_i[0];
        CfgByteSwap:  swap_q       <= cfg_wdata_i[0];
        CfgReplyMask: reply_mask_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Open a block on its first byte: clamp size and clear latches
  always_comb begin
    size_in = (block_size_i == 17'd0) ? 17'd1 : block_size_i;
    if ({15'd0, size_in} > MaxBytes) begin
      size_in = MaxBytes[16:0];
    end
  end

  always_comb begin
    st0 = st_q;
    if (st_q.phase == PhIdle) begin
      st0       = '0;
      st0.phase = PhHeader;
      st0.size  = size_in;
    end
  end

  logic [16:0] pos_cur;
  logic [7:0]  held_cur;
  assign pos_cur  = (st_q.phase == PhIdle) ? 17'd0 : pos_q;
  assign held_cur = (st_q.phase == PhIdle) ? 8'h00 : held_q;
  assign pos_last = (({1'b0, pos_cur} + 18'd1) == {1'b0, st0.size});

  // Route bytes through up to two parse steps (swapped pairs give two)
  always_comb begin
    f1_en   = !swap_q || pos_cur[0] || pos_last;
    f2_en   = swap_q && pos_cur[0];
    f1_byte = (swap_q && !pos_cur[0]) ? 8'h00 : data_byte_i;
    f1_pos  = (swap_q && pos_cur[0]) ? pos_cur - 17'd1 : pos_cur;
  end

  assign f1 = bhd_feed(st0, f1_byte, f1_pos, sec_en_q, reply_mask_q);
  assign f2 = bhd_feed(f1.st, held_cur, pos_cur, sec_en_q, reply_mask_q);

  // Next parser state
  always_comb begin
    st_d   = st_q;
    pos_d  = pos_q;
    held_d = held_q;
    if (in_acc) begin
      held_d = held_cur;
      if (f2_en) begin
        st_d = f2.st;
      end else if (f1_en) begin
        st_d = f1.st;
      end else begin
        st_d   = st0;
        held_d = data_byte_i;
      end
      if (({1'b0, pos_cur} + 18'd1) >= {1'b0, st0.size}) begin
        st_d.phase = PhIdle;
        pos_d      = '0;
      end else begin
        pos_d = pos_cur + 17'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      pos_q  <= '0;
      held_q <= '0;
    end else begin
      st_q   <= st_d;
      pos_q  <= pos_d;
      held_q <= held_d;
    end
  end

  // Pack the produced results in order
  always_comb begin
    w0_vld = 1'b0;
    w1_vld = 1'b0;
    w0_res = f1.res;
    w1_res = f2.res;
    if (in_acc) begin
      if (f1_en && f1.vld) begin
        w0_vld = 1'b1;
        w1_vld = f2_en && f2.vld;
      end else if (f2_en && f2.vld) begin
        w0_vld = 1'b1;
        w0_res = f2.res;
      end
    end
  end

  // Result queue: write up to two, pop one
  always_ff @(posedge clk_i) begin
    if (w0_vld) begin
      fifo_q[wr_q] <= w0_res;
    end
    if (w1_vld) begin
      fifo_q[wr_q + OutPtrW'(1)] <= w1_res;
    end
  end

  always_comb begin
    cnt_d = cnt_q + OutCntW'(w0_vld) + OutCntW'(w1_vld) - OutCntW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OutPtrW'(w0_vld) + OutPtrW'(w1_vld);
      rd_q  <= rd_q + OutPtrW'(out_acc);
      cnt_q <= cnt_d;
    end
  end

  assign in_ready_o  = (cnt_q <= OutCntW'(OutDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign head        = fifo_q[rd_q];

  assign kind_o           = head.kind;
  assign block_type_o     = head.block_type;
  assign node_address_o   = head.node_address;
  assign data_type_o      = head.data_type;
  assign command_tag_o    = head.command_tag;
  assign error_code_o     = head.error_code;
  assign data_time_o      = head.data_time;
  assign payload_length_o = head.payload_length;
  assign payload_byte_o   = head.payload_byte;
  assign last_o           = head.last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OutCntW'(OutDepth))
    else $error("result queue overflow");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindError) |-> last_o)
    else $error("format error result without last");

  a_size_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase != PhIdle) |-> (st_q.size != '0 && pos_q < st_q.size))
    else $error("byte position outside block");

  a_payload_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PhPayload) |-> (st_q.hdr_len != '0))
    else $error("payload phase without header length");

endmodule

// File: test/bhd_checker.sv
// ----------------------------------------------------------------------------
// bhd_checker: result predictor and scoreboard for block_header_deframer
// Watches the input, output and register-write ports, predicts the results
// that every accepted byte request causes and compares each accepted result,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhd_checker #(
  parameter int unsigned MaxBlockBytes = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [16:0] block_size_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_o,
  input  logic [1:0]  block_type_o,
  input  logic [8:0]  node_address_o,
  input  logic [20:0] data_type_o,
  input  logic [11:0] command_tag_o,
  input  logic [3:0]  error_code_o,
  input  logic [31:0] data_time_o,
  input  logic [16:0] payload_length_o,
  input  logic [7:0]  payload_byte_o,
  input  logic        last_o,
  input  logic        drain_done_i,
  output int          mismatch_count_o,
  output int          results_due_o
);
  import bhd_pkg::*;

  // Register copies
  logic        sec_en;
  logic        swap_en;
  logic [1:0]  reply_mask;

  // Parse state
  logic [1:0]  phase_q;
  logic [16:0] byte_pos;
  logic [16:0] blk_size;
  logic [7:0]  held_byte;
  logic [15:0] hdr_word;
  logic [20:0] type_word;
  logic [15:0] tag_err_word;
  logic [31:0] time_word;
  logic [3:0]  hdr_len;

  result_t     results_due[$];
  result_t     seen_res;
  result_t     due_res;
  int          mismatch_count;
  bit          drain_seen;

  assign mismatch_count_o = mismatch_count;

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s is %0h, should be %0h", name, got, want));
  endtask

  // Apply one byte (after any pair swap) at block position pos.
  task automatic parse_byte(input logic [7:0] b, input logic [16:0] pos);
    result_t     r;
    logic        at_end;
    int unsigned prim;
    int unsigned rem;
    int unsigned sec;
    r      = '0;
    at_end = (32'(pos) + 1 == 32'(blk_size));
    if (phase_q == PhPayload) begin
      r.kind         = KindPayload;
      r.payload_byte = b;
      r.last         = at_end;
      results_due.push_back(r);
      return;
    end
    if (phase_q == PhHeader) begin
      if (pos == 0) begin
        hdr_word = {b, 8'h00};
      end else if (pos == 1) begin
        hdr_word[7:0] = b;
        type_word     = {16'd0, b[4:0]};
        prim          = (b[4:0] == TypeExt) ? 4 : 2;
        if (32'(blk_size) < prim) begin
          phase_q = PhTrunc;
        end else begin
          rem = 32'(blk_size) - prim;
          sec = 0;
          if (sec_en && rem > 0) begin
            sec = ((hdr_word[15:14] & reply_mask) != 2'd0) ? 6 : 2;
          end
          if (rem < sec) phase_q = PhTrunc;
          else hdr_len = 4'(prim + sec);
        end
      end else begin
        // extension bytes, then the tag/error word, then the time word
        prim = (type_word[4:0] == TypeExt || type_word[20:5] != 16'd0) ? 4 : 2;
        if (prim == 4 && pos < 4) type_word = {type_word[12:0], b};
        else if (32'(pos) - prim < 2) tag_err_word = {tag_err_word[7:0], b};
        else time_word = {time_word[23:0], b};
      end
      if (phase_q == PhHeader && pos >= 1 && 32'(pos) + 1 == 32'(hdr_len)) begin
        r.kind           = KindHeader;
        r.block_type     = hdr_word[15:14];
        r.node_address   = hdr_word[13:5];
        r.data_type      = type_word;
        r.command_tag    = tag_err_word[11:0];
        r.error_code     = tag_err_word[15:12];
        r.data_time      = time_word;
        r.payload_length = blk_size - 17'(hdr_len);
        r.last           = at_end;
        results_due.push_back(r);
        phase_q = PhPayload;
        return;
      end
    end
    if ((phase_q == PhHeader || phase_q == PhTrunc) && at_end) begin
      r.kind = KindError;
      r.last = 1'b1;
      results_due.push_back(r);
    end
  endtask

  // Take one accepted byte request: open a block if idle, undo the pair swap.
  task automatic take_byte(input logic [7:0] d, input logic [16:0] s);
    logic [16:0] pos;
    if (phase_q == PhIdle) begin
      if (s == 0) blk_size = 17'd1;
      else if (32'(s) > MaxBlockBytes) blk_size = 17'(MaxBlockBytes);
      else blk_size = s;
      byte_pos     = '0;
      hdr_word     = '0;
      type_word    = '0;
      tag_err_word = '0;
      time_word    = '0;
      hdr_len      = '0;
      held_byte    = '0;
      phase_q      = PhHeader;
    end
    pos = byte_pos;
    if (!swap_en) begin
      parse_byte(d, pos);
    end else if (!pos[0]) begin
      if (32'(pos) + 1 == 32'(blk_size)) parse_byte(8'h00, pos);
      else held_byte = d;
    end else begin
      parse_byte(d, pos - 17'd1);
      parse_byte(held_byte, pos);
    end
    if (32'(pos) + 1 >= 32'(blk_size)) begin
      phase_q  = PhIdle;
      byte_pos = '0;
    end else begin
      byte_pos = pos + 17'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_en         = 1'b1;
      swap_en        = 1'b0;
      reply_mask     = 2'd2;
      phase_q        = PhIdle;
      byte_pos       = '0;
      blk_size       = '0;
      held_byte      = '0;
      hdr_word       = '0;
      type_word      = '0;
      tag_err_word   = '0;
      time_word      = '0;
      hdr_len        = '0;
      mismatch_count = 0;
      drain_seen     = 1'b0;
      results_due.delete();
      results_due_o <= 0;
    end else begin
      // compare an accepted result with the oldest prediction
      if (out_valid_o && out_ready_i) begin
        seen_res = {kind_o, block_type_o, node_address_o, data_type_o, command_tag_o,
                    error_code_o, data_time_o, payload_length_o, payload_byte_o, last_o};
        if (results_due.size() == 0) begin
          report($sformatf("result kind %0d arrived with none predicted", kind_o));
        end else begin
          due_res = results_due.pop_front();
          check_field("kind", 32'(seen_res.kind), 32'(due_res.kind));
          check_field("block_type", 32'(seen_res.block_type), 32'(due_res.block_type));
          check_field("node_address", 32'(seen_res.node_address),
                      32'(due_res.node_address));
          check_field("data_type", 32'(seen_res.data_type), 32'(due_res.data_type));
          check_field("command_tag", 32'(seen_res.command_tag),
                      32'(due_res.command_tag));
          check_field("error_code", 32'(seen_res.error_code), 32'(due_res.error_code));
          check_field("data_time", seen_res.data_time, due_res.data_time);
          check_field("payload_length", 32'(seen_res.payload_length),
                      32'(due_res.payload_length));
          check_field("payload_byte", 32'(seen_res.payload_byte),
                      32'(due_res.payload_byte));
          check_field("last", 32'(seen_res.last), 32'(due_res.last));
        end
      end
      // track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSecHdrEn:  sec_en = cfg_wdata_i[0];
          CfgByteSwap:  swap_en = cfg_wdata_i[0];
          CfgReplyMask: reply_mask = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_o) take_byte(data_byte_i, block_size_i);
      // flag predictions never matched once the stream has drained
      if (drain_done_i && !drain_seen) begin
        drain_seen = 1'b1;
        if (results_due.size() != 0) begin
          report($sformatf("%0d predicted results never arrived", results_due.size()));
        end
      end
      results_due_o <= results_due.size();
    end
  end

endmodule

// File: test/tb_block_header_deframer.sv
// ----------------------------------------------------------------------------
// tb_block_header_deframer: stimulus and verdict for block_header_deframer
// Sends directed corner blocks, then random blocks under changing register
// settings with bursty byte requests and a stalling receiver. A separate
// checker predicts and compares all results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_block_header_deframer;
  import bhd_pkg::*;

  localparam int unsigned MaxBlockBytes = 65536;
  localparam int unsigned CycleLimit    = 3000000;
  localparam int unsigned PhaseBytes    = 50;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_idx_i    = '0;
  logic [1:0]  cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i  = '0;
  logic [16:0] block_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  kind_o;
  logic [1:0]  block_type_o;
  logic [8:0]  node_address_o;
  logic [20:0] data_type_o;
  logic [11:0] command_tag_o;
  logic [3:0]  error_code_o;
  logic [31:0] data_time_o;
  logic [16:0] payload_length_o;
  logic [7:0]  payload_byte_o;
  logic        last_o;
  logic        drain_done   = 1'b0;
  int          mismatch_count;
  int          results_due;

  // Pacing state of the sender
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;
  bit          swap_mode  = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_tick = 0;
  int unsigned rx_mode = 0;

  block_header_deframer #(
    .MAX_BLOCK_BYTES(MaxBlockBytes)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .block_size_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .block_type_o,
    .node_address_o,
    .data_type_o,
    .command_tag_o,
    .error_code_o,
    .data_time_o,
    .payload_length_o,
    .payload_byte_o,
    .last_o
  );

  bhd_checker #(
    .MaxBlockBytes(MaxBlockBytes)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .block_size_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .block_type_o,
    .node_address_o,
    .data_type_o,
    .command_tag_o,
    .error_code_o,
    .data_time_o,
    .payload_length_o,
    .payload_byte_o,
    .last_o,
    .drain_done_i(drain_done),
    .mismatch_count_o(mismatch_count),
    .results_due_o(results_due)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: switch between always ready, coin flips, sparse and rare stalls
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (rx_tick % 3 == 0);
      default: out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Offer one byte request and hold it until accepted; gaps fall between bursts.
  task automatic push_byte(input logic [7:0] d, input logic [16:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        gap = $urandom_range(1, 5);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    data_byte_i  <= d;
    block_size_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // Drain all predicted results, let the block settle, then write all registers.
  task automatic apply_config(input logic sec, input logic swp, input logic [1:0] mask);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgSecHdrEn;
    cfg_wdata_i <= {1'b0, sec};
    @(posedge clk_i);
    cfg_idx_i   <= CfgByteSwap;
    cfg_wdata_i <= {1'b0, swp};
    @(posedge clk_i);
    cfg_idx_i   <= CfgReplyMask;
    cfg_wdata_i <= mask;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    swap_mode = swp;
  endtask

  // Send one block that starts with hword; with swap on, pre-swap the pairs so
  // the header lands where intended. Before byte cut_at, change the registers.
  task automatic send_block(input logic [16:0] size_field, input logic [15:0] hword,
                            input int cut_at);
    logic [7:0] blk[$];
    logic [7:0] raw;
    int         n;
    bit         swp;
    if (size_field == 0) n = 1;
    else if (32'(size_field) > MaxBlockBytes) n = MaxBlockBytes;
    else n = int'(size_field);
    swp = swap_mode;
    for (int i = 0; i < n; i++) blk.push_back(8'($urandom_range(0, 255)));
    blk[0] = hword[15:8];
    if (n > 1) blk[1] = hword[7:0];
    for (int i = 0; i < n; i++) begin
      if (!swp) raw = blk[i];
      else if (i % 2 == 1) raw = blk[i - 1];
      else if (i + 1 < n) raw = blk[i + 1];
      else raw = blk[i];
      if (i == cut_at) begin
        apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     2'($urandom_range(0, 3)));
      end
      push_byte(raw, (i == 0) ? size_field : 17'($urandom_range(0, 131071)));
    end
  endtask

  function automatic logic [15:0] random_hword();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(0, 9) < 3) w[4:0] = TypeExt;
    return w;
  endfunction

  // Mostly sizes that hold a full header, some truncated, a few longer ones
  function automatic logic [16:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 17'($urandom_range(0, 11));
    if (r < 90) return 17'($urandom_range(12, 40));
    return 17'($urandom_range(41, 120));
  endfunction

  initial begin
    int unsigned phase_end;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners at the reset register values
    apply_config(1'b1, 1'b0, 2'd2);
    send_block(17'd0, {2'd0, 9'd0, 5'd0}, -1);       // zero size: one-byte error
    send_block(17'd2, {2'd1, 9'h1FF, 5'd3}, -1);     // no room left for secondary
    send_block(17'd3, {2'd2, 9'd5, 5'd1}, -1);       // reply header truncated
    send_block(17'd4, {2'd1, 9'd7, 5'd2}, -1);       // tag/error only, empty payload
    send_block(17'd3, {2'd0, 9'd1, TypeExt}, -1);    // extension cut short
    send_block(17'd11, 16'hFFFF, -1);                // extended reply, one payload byte

    // Swap with odd sizes, no secondary header
    apply_config(1'b0, 1'b1, 2'd3);
    send_block(17'd1, {2'd2, 9'd9, 5'd4}, -1);       // lone byte becomes the pad
    send_block(17'd5, {2'd2, 9'd100, 5'd9}, -1);
    send_block(17'd7, {2'd3, 9'd33, TypeExt}, -1);

    // Registers change between the first and second byte of a block
    apply_config(1'b1, 1'b0, 2'd0);
    send_block(17'd9, {2'd3, 9'd3, 5'd4}, 1);
    apply_config(1'b1, 1'b1, 2'd3);
    send_block(17'd11, {2'd2, 9'd77, 5'd0}, -1);

    // Random blocks, a fresh register setting per phase
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) apply_config(1'b0, 1'b0, 2'd0);
      else if (ph == 1) apply_config(1'b1, 1'b1, 2'd3);
      else apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        2'($urandom_range(0, 3)));
      steady    = (ph == 5);
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) begin
        send_block(pick_size(), random_hword(),
                   ($urandom_range(0, 99) < 15) ? int'($urandom_range(1, 3)) : -1);
      end
    end

    // Drain and give the verdict
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
